// ===== sv/pending_packet_buffer_by_destination_defines.svh =====
// ----------------------------------------------------------------------------
// Pending packet buffer assertion macros
// Shorthand for clocked immediate-implication and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef PENDING_PACKET_BUFFER_BY_DESTINATION_DEFINES_SVH
`define PENDING_PACKET_BUFFER_BY_DESTINATION_DEFINES_SVH

// same-cycle implication
`define PPBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPBD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ppbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppbd_pkg
// Shared types, codes and constants of the pending packet buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppbd_pkg;

   localparam int DEST_SLOTS_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 8;

   localparam int REQ_W    = 3;
   localparam int DEST_W   = 16;
   localparam int HANDLE_W = 16;
   localparam int CNT_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

   typedef enum logic [REQ_W-1:0] {
      REQ_TRAP       = 3'd0,
      REQ_RELEASE    = 3'd1,
      REQ_REMOVE     = 3'd2,
      REQ_COUNT_DEST = 3'd3,
      REQ_COUNT_ALL  = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 2'd0,
      STS_EMPTY    = 2'd1,
      STS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_DECIDE,
      S_DRAIN,
      S_DRAIN_END
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic match_all;
   } scan_ctl_type;

   typedef struct packed {
      logic hit;
      logic free;
   } scan_flags_type;

   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ppbd_ram.sv =====
// ----------------------------------------------------------------------------
// ppbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppbd_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ppbd_scan.sv =====
// ----------------------------------------------------------------------------
// ppbd_scan
// Shared compare/accumulate unit: one table slot per stepped cycle; tracks
// the matching slot, the lowest free slot and the running packet total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppbd_scan #(
   parameter int DEST_SLOTS  = ppbd_pkg::DEST_SLOTS_DEF,
   parameter int QUEUE_DEPTH = ppbd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ppbd_pkg::scan_ctl_type                scan_ctl,
   input  wire logic [ppbd_pkg::DEST_W-1:0]           key,
   input  wire logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0] elem_idx,
   input  wire logic                                  elem_valid,
   input  wire logic [ppbd_pkg::DEST_W-1:0]           elem_dest,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]      elem_fill,
   output      ppbd_pkg::scan_flags_type              flags,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0] hit_idx,
   output      logic [$clog2(QUEUE_DEPTH+1)-1:0]      hit_fill,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0] free_idx,
   output      logic [$clog2(DEST_SLOTS*QUEUE_DEPTH+1)-1:0] total
);

   import ppbd_pkg::*;

   localparam int SLOT_W  = idx_w(DEST_SLOTS);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL_W = $clog2(DEST_SLOTS * QUEUE_DEPTH + 1);

   scan_flags_type     flags_ff, flags_in;
   logic [SLOT_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [FILL_W-1:0]  hit_fill_ff, hit_fill_in;
   logic [SLOT_W-1:0]  free_idx_ff, free_idx_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               dest_eq;

   always_comb begin
      dest_eq     = (elem_dest == key);
      flags_in    = flags_ff;
      hit_idx_in  = hit_idx_ff;
      hit_fill_in = hit_fill_ff;
      free_idx_in = free_idx_ff;
      total_in    = total_ff;
      priority if (scan_ctl.clear) begin
         flags_in = '0;
         total_in = '0;
      end else if (scan_ctl.step) begin
         if (elem_valid && dest_eq && !flags_ff.hit) begin
            flags_in.hit = 1'b1;
            hit_idx_in   = elem_idx;
            hit_fill_in  = elem_fill;
         end
         if (!elem_valid && !flags_ff.free) begin
            flags_in.free = 1'b1;
            free_idx_in   = elem_idx;
         end
         if (elem_valid && (scan_ctl.match_all || dest_eq)) begin
            total_in = total_ff + TOTAL_W'(elem_fill);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         total_ff <= '0;
      end else begin
         flags_ff <= flags_in;
         total_ff <= total_in;
      end
      hit_idx_ff  <= hit_idx_in;
      hit_fill_ff <= hit_fill_in;
      free_idx_ff <= free_idx_in;
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_idx_ff;
   assign hit_fill = hit_fill_ff;
   assign free_idx = free_idx_ff;
   assign total    = total_ff;

endmodule

`default_nettype wire

// ===== sv/ppbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppbd_ctrl
// Sequencer: slot table registers, request decode, scan and drain stepping,
// and the registered result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppbd_ctrl #(
   parameter int DEST_SLOTS  = ppbd_pkg::DEST_SLOTS_DEF,
   parameter int QUEUE_DEPTH = ppbd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output      logic                                    busy,
   input  wire logic [ppbd_pkg::REQ_W-1:0]              req_type,
   input  wire logic [ppbd_pkg::DEST_W-1:0]             req_dest_addr,
   input  wire logic [ppbd_pkg::HANDLE_W-1:0]           req_packet_handle,
   input  wire logic                                    req_route_ready,
   output      logic                                    rsp_strobe,
   output      logic [ppbd_pkg::HANDLE_W-1:0]           rsp_out_handle,
   output      logic                                    rsp_handle_valid,
   output      logic [ppbd_pkg::CNT_W-1:0]              rsp_queued_count,
   output      logic [ppbd_pkg::STATUS_W-1:0]           rsp_status,
   output      logic                                    rsp_table_empty,
   output      logic                                    rsp_last,
   // scan unit
   output      ppbd_pkg::scan_ctl_type                  scan_ctl,
   output      logic [ppbd_pkg::DEST_W-1:0]             scan_key,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0]  elem_idx,
   output      logic                                    elem_valid,
   output      logic [$clog2(QUEUE_DEPTH+1)-1:0]        elem_fill,
   input  wire ppbd_pkg::scan_flags_type                scan_flags,
   input  wire logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0]  hit_idx,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]        hit_fill,
   input  wire logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0]  free_idx,
   input  wire logic [$clog2(DEST_SLOTS*QUEUE_DEPTH+1)-1:0] total,
   // destination RAM
   output      logic                                    dest_wr_en,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0]  dest_wr_addr,
   output      logic [ppbd_pkg::DEST_W-1:0]             dest_wr_data,
   output      logic                                    dest_rd_en,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS)-1:0]  dest_rd_addr,
   // handle store RAM
   output      logic                                    store_wr_en,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS*QUEUE_DEPTH)-1:0] store_wr_addr,
   output      logic [ppbd_pkg::HANDLE_W-1:0]           store_wr_data,
   output      logic                                    store_rd_en,
   output      logic [ppbd_pkg::idx_w(DEST_SLOTS*QUEUE_DEPTH)-1:0] store_rd_addr,
   input  wire logic [ppbd_pkg::HANDLE_W-1:0]           store_rd_data
);

   import ppbd_pkg::*;

   localparam int SLOT_W     = idx_w(DEST_SLOTS);
   localparam int QIDX_W     = idx_w(QUEUE_DEPTH);
   localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_AW   = idx_w(DEST_SLOTS * QUEUE_DEPTH);
   localparam int TOTAL_W    = $clog2(DEST_SLOTS * QUEUE_DEPTH + 1);
   localparam int CMP_W      = (TOTAL_W > CNT_W) ? TOTAL_W : CNT_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEST_SLOTS - 1);

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [QIDX_W-1:0]       drain_idx_ff, drain_idx_in;
   logic [DEST_SLOTS-1:0]   slot_valid_ff, slot_valid_in;
   logic [FILL_W-1:0]       slot_fill_ff [DEST_SLOTS];
   logic [FILL_W-1:0]       slot_fill_in [DEST_SLOTS];

   logic [REQ_W-1:0]        req_type_ff, req_type_in;
   logic [DEST_W-1:0]       dest_ff, dest_in;
   logic [HANDLE_W-1:0]     handle_ff, handle_in;
   logic                    ready_ff, ready_in;

   logic                    step_ff, step_in;
   logic [SLOT_W-1:0]       step_idx_ff;
   logic                    step_sv_ff;
   logic [FILL_W-1:0]       step_fill_ff;

   logic                    drain_v_ff, drain_v_in;
   logic                    drain_last_ff, drain_last_in;

   logic                    res_load;
   status_type              res_status;
   logic [CNT_W-1:0]        res_count;

   logic                    rsp_strobe_ff;
   logic [HANDLE_W-1:0]     rsp_handle_ff;
   logic                    rsp_hv_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic                    rsp_empty_ff;
   logic                    rsp_last_ff;

   logic [SLOT_W-1:0]       trap_slot;
   logic [FILL_W-1:0]       trap_pos;
   logic [CNT_W-1:0]        total_sat;
   logic                    drain_at_end;

   always_comb begin
      trap_slot = scan_flags.hit ? hit_idx : free_idx;
      trap_pos  = scan_flags.hit ? hit_fill : '0;
      total_sat = (CMP_W'(total) > CMP_W'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(total);
      drain_at_end = ((FILL_W'(drain_idx_ff) + FILL_W'(1)) == hit_fill);
   end

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      drain_idx_in  = drain_idx_ff;
      slot_valid_in = slot_valid_ff;
      slot_fill_in  = slot_fill_ff;
      req_type_in   = req_type_ff;
      dest_in       = dest_ff;
      handle_in     = handle_ff;
      ready_in      = ready_ff;
      step_in       = 1'b0;
      drain_v_in    = 1'b0;
      drain_last_in = 1'b0;
      res_load      = 1'b0;
      res_status    = STS_OK;
      res_count     = '0;

      scan_ctl.clear     = 1'b0;
      scan_ctl.step      = step_ff;
      scan_ctl.match_all = (req_type_ff == REQ_COUNT_ALL);

      dest_wr_en    = 1'b0;
      dest_wr_addr  = free_idx;
      dest_wr_data  = dest_ff;
      dest_rd_en    = 1'b0;
      dest_rd_addr  = scan_idx_ff;
      store_wr_en   = 1'b0;
      store_wr_addr = STORE_AW'(trap_slot) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(trap_pos);
      store_wr_data = handle_ff;
      store_rd_en   = 1'b0;
      store_rd_addr = STORE_AW'(hit_idx) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(drain_idx_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_type_in    = req_type;
               dest_in        = req_dest_addr;
               handle_in      = req_packet_handle;
               ready_in       = req_route_ready;
               scan_ctl.clear = 1'b1;
               scan_idx_in    = '0;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            dest_rd_en = 1'b1;
            step_in    = 1'b1;
            if (scan_idx_ff == LAST_SLOT) begin
               state_in = S_SCAN_END;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_W'(1);
            end
         end
         S_SCAN_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            res_load = 1'b1;
            state_in = S_IDLE;
            unique case (req_type_ff)
               REQ_TRAP: begin
                  if (scan_flags.hit) begin
                     if (hit_fill >= FILL_W'(QUEUE_DEPTH)) begin
                        res_status = STS_OVERFLOW;
                     end else begin
                        store_wr_en           = 1'b1;
                        slot_fill_in[hit_idx] = hit_fill + FILL_W'(1);
                     end
                  end else if (scan_flags.free) begin
                     store_wr_en              = 1'b1;
                     dest_wr_en               = 1'b1;
                     slot_valid_in[free_idx]  = 1'b1;
                     slot_fill_in[free_idx]   = FILL_W'(1);
                  end else begin
                     res_status = STS_OVERFLOW;
                  end
               end
               REQ_RELEASE, REQ_REMOVE: begin
                  if (!scan_flags.hit || hit_fill == '0 ||
                      (req_type_ff == REQ_RELEASE && !ready_ff)) begin
                     res_status = STS_EMPTY;
                  end else begin
                     res_load               = 1'b0;
                     slot_valid_in[hit_idx] = 1'b0;
                     slot_fill_in[hit_idx]  = '0;
                     drain_idx_in           = '0;
                     state_in               = S_DRAIN;
                  end
               end
               REQ_COUNT_DEST, REQ_COUNT_ALL: begin
                  res_count = total_sat;
               end
               default: begin
                  res_status = STS_EMPTY;
               end
            endcase
         end
         S_DRAIN: begin
            store_rd_en   = 1'b1;
            drain_v_in    = 1'b1;
            drain_last_in = drain_at_end;
            if (drain_at_end) begin
               state_in = S_DRAIN_END;
            end else begin
               drain_idx_in = drain_idx_ff + QIDX_W'(1);
            end
         end
         S_DRAIN_END: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         for (int i = 0; i < DEST_SLOTS; i++) begin
            slot_fill_ff[i] <= '0;
         end
         step_ff       <= 1'b0;
         drain_v_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         slot_fill_ff  <= slot_fill_in;
         step_ff       <= step_in;
         drain_v_ff    <= drain_v_in;
         rsp_strobe_ff <= res_load | drain_v_ff;
      end
      scan_idx_ff   <= scan_idx_in;
      drain_idx_ff  <= drain_idx_in;
      req_type_ff   <= req_type_in;
      dest_ff       <= dest_in;
      handle_ff     <= handle_in;
      ready_ff      <= ready_in;
      step_idx_ff   <= scan_idx_ff;
      step_sv_ff    <= slot_valid_ff[scan_idx_ff];
      step_fill_ff  <= slot_fill_ff[scan_idx_ff];
      drain_last_ff <= drain_last_in;
      if (res_load) begin
         rsp_handle_ff <= '0;
         rsp_hv_ff     <= 1'b0;
         rsp_count_ff  <= res_count;
         rsp_status_ff <= res_status;
         rsp_empty_ff  <= ~|slot_valid_in;
         rsp_last_ff   <= 1'b1;
      end else if (drain_v_ff) begin
         rsp_handle_ff <= store_rd_data;
         rsp_hv_ff     <= 1'b1;
         rsp_count_ff  <= '0;
         rsp_status_ff <= STS_OK;
         rsp_empty_ff  <= ~|slot_valid_ff;
         rsp_last_ff   <= drain_last_ff;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign scan_key         = dest_ff;
   assign elem_idx         = step_idx_ff;
   assign elem_valid       = step_sv_ff;
   assign elem_fill        = step_fill_ff;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_handle_valid = rsp_hv_ff;
   assign rsp_queued_count = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_table_empty  = rsp_empty_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/pending_packet_buffer_by_destination.sv =====
// ----------------------------------------------------------------------------
// pending_packet_buffer_by_destination
// Packet handles parked per destination in FIFO queues; trap, drain and count.
//
//   channel   ports                   transfer when
//   request   start/busy, req_*       start high, busy low
//   result    rsp_strobe, rsp_*       rsp_strobe high (one cycle, no stall)
//
// Every request first scans the destination table one slot a cycle through
// the shared compare unit, then S_SCAN_END and S_DECIDE; a single result
// strobes in the cycle after S_DECIDE. A drain runs S_DRAIN, S_DRAIN_END and
// emits one handle per cycle, oldest first. Reset is synchronous and empties
// the table at once. start is ignored while busy; results cannot be held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pending_packet_buffer_by_destination #(
   parameter int DEST_SLOTS  = ppbd_pkg::DEST_SLOTS_DEF,
   parameter int QUEUE_DEPTH = ppbd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [ppbd_pkg::REQ_W-1:0]    req_type,
   input  wire logic [ppbd_pkg::DEST_W-1:0]   req_dest_addr,
   input  wire logic [ppbd_pkg::HANDLE_W-1:0] req_packet_handle,
   input  wire logic                          req_route_ready,
   output      logic                          rsp_strobe,
   output      logic [ppbd_pkg::HANDLE_W-1:0] rsp_out_handle,
   output      logic                          rsp_handle_valid,
   output      logic [ppbd_pkg::CNT_W-1:0]    rsp_queued_count,
   output      logic [ppbd_pkg::STATUS_W-1:0] rsp_status,
   output      logic                          rsp_table_empty,
   output      logic                          rsp_last
);

   import ppbd_pkg::*;

   localparam int SLOT_W   = idx_w(DEST_SLOTS);
   localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_D  = DEST_SLOTS * QUEUE_DEPTH;
   localparam int STORE_AW = idx_w(STORE_D);
   localparam int TOTAL_W  = $clog2(STORE_D + 1);

   scan_ctl_type          scan_ctl;
   scan_flags_type        scan_flags;
   logic [DEST_W-1:0]     scan_key;
   logic [SLOT_W-1:0]     elem_idx;
   logic                  elem_valid;
   logic [FILL_W-1:0]     elem_fill;
   logic [SLOT_W-1:0]     hit_idx;
   logic [FILL_W-1:0]     hit_fill;
   logic [SLOT_W-1:0]     free_idx;
   logic [TOTAL_W-1:0]    total;

   logic                  dest_wr_en;
   logic [SLOT_W-1:0]     dest_wr_addr;
   logic [DEST_W-1:0]     dest_wr_data;
   logic                  dest_rd_en;
   logic [SLOT_W-1:0]     dest_rd_addr;
   logic [DEST_W-1:0]     dest_rd_data;

   logic                  store_wr_en;
   logic [STORE_AW-1:0]   store_wr_addr;
   logic [HANDLE_W-1:0]   store_wr_data;
   logic                  store_rd_en;
   logic [STORE_AW-1:0]   store_rd_addr;
   logic [HANDLE_W-1:0]   store_rd_data;

   ppbd_ram #(
      .WIDTH  (DEST_W),
      .DEPTH  (DEST_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_dest_ram (
      .clock   (clock),
      .wr_en   (dest_wr_en),
      .wr_addr (dest_wr_addr),
      .wr_data (dest_wr_data),
      .rd_en   (dest_rd_en),
      .rd_addr (dest_rd_addr),
      .rd_data (dest_rd_data)
   );

   ppbd_ram #(
      .WIDTH  (HANDLE_W),
      .DEPTH  (STORE_D),
      .ADDR_W (STORE_AW)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   ppbd_scan #(
      .DEST_SLOTS  (DEST_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_ctl   (scan_ctl),
      .key        (scan_key),
      .elem_idx   (elem_idx),
      .elem_valid (elem_valid),
      .elem_dest  (dest_rd_data),
      .elem_fill  (elem_fill),
      .flags      (scan_flags),
      .hit_idx    (hit_idx),
      .hit_fill   (hit_fill),
      .free_idx   (free_idx),
      .total      (total)
   );

   ppbd_ctrl #(
      .DEST_SLOTS  (DEST_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_dest_addr     (req_dest_addr),
      .req_packet_handle (req_packet_handle),
      .req_route_ready   (req_route_ready),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_handle_valid  (rsp_handle_valid),
      .rsp_queued_count  (rsp_queued_count),
      .rsp_status        (rsp_status),
      .rsp_table_empty   (rsp_table_empty),
      .rsp_last          (rsp_last),
      .scan_ctl          (scan_ctl),
      .scan_key          (scan_key),
      .elem_idx          (elem_idx),
      .elem_valid        (elem_valid),
      .elem_fill         (elem_fill),
      .scan_flags        (scan_flags),
      .hit_idx           (hit_idx),
      .hit_fill          (hit_fill),
      .free_idx          (free_idx),
      .total             (total),
      .dest_wr_en        (dest_wr_en),
      .dest_wr_addr      (dest_wr_addr),
      .dest_wr_data      (dest_wr_data),
      .dest_rd_en        (dest_rd_en),
      .dest_rd_addr      (dest_rd_addr),
      .store_wr_en       (store_wr_en),
      .store_wr_addr     (store_wr_addr),
      .store_wr_data     (store_wr_data),
      .store_rd_en       (store_rd_en),
      .store_rd_addr     (store_rd_addr),
      .store_rd_data     (store_rd_data)
   );

endmodule

`default_nettype wire

// ===== sv/ppbd_checker.sv =====
// ----------------------------------------------------------------------------
// ppbd_checker
// Port-level checks of the pending packet buffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pending_packet_buffer_by_destination_defines.svh"

module ppbd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_strobe,
   input wire logic [ppbd_pkg::HANDLE_W-1:0] rsp_out_handle,
   input wire logic                          rsp_handle_valid,
   input wire logic [ppbd_pkg::CNT_W-1:0]    rsp_queued_count,
   input wire logic [ppbd_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                          rsp_last
);

   import ppbd_pkg::*;

   `PPBD_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after transfer")
   `PPBD_ASSERT_NXT(a_drain_burst, clock, reset, rsp_strobe && !rsp_last, rsp_strobe, "gap inside drain burst")
   `PPBD_ASSERT_NOW(a_no_handle_zero, clock, reset, rsp_strobe && !rsp_handle_valid, rsp_out_handle == '0, "handle not zero")
   `PPBD_ASSERT_NOW(a_handle_ok, clock, reset, rsp_strobe && rsp_handle_valid, rsp_status == STS_OK && rsp_queued_count == '0, "drained handle with status or count")
   `PPBD_ASSERT_NOW(a_single_last, clock, reset, rsp_strobe && !rsp_handle_valid, rsp_last, "single result without last")

endmodule

bind pending_packet_buffer_by_destination ppbd_checker u_checker (.*);

`default_nettype wire
